[rtl/ssen_pkg.sv]
// Package for the searchable stack engine: request and response beat types,
// mode and status codes, the per-cell control word and sizing constants.
// No dependencies.
package ssen_pkg;

   // Sizing
   localparam int DEPTH       = 16;
   localparam int MAX_RESULTS = 16;
   localparam int DATA_W      = 32;
   localparam int MODE_W      = 3;
   localparam int STATUS_W    = 3;
   localparam int POS_W       = 4;
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MODIFY = 3'd2;
   localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DUMP   = 3'd4;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_DUMP      = 3'd4;

   typedef struct packed {
      logic [MODE_W-1:0]        mode;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } rsp_type;

   // Operation broadcast to every cell in the row
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_MODIFY,
      CELL_DELETE
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] new_value;
   } cell_ctrl_type;

endpackage

[rtl/searchable_stack_engine.sv]
// Searchable stack engine: bounded stack in a row of compare-and-shift cells.
// Push, search, modify and delete finish in the cycle they are accepted, the
// registered result strobes in the next cycle, and a request is taken every
// cycle while not busy. A non-empty dump sets busy, then gives one entry per
// cycle, min(count, 16) registered beats read by a counter from the cell row.
// Synchronous reset empties the stack and clears busy and the strobe.
module searchable_stack_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ssen_pkg::req_type req_data,
   output logic              rsp_strobe,
   output ssen_pkg::rsp_type rsp_data
);

   localparam int DEPTH = ssen_pkg::DEPTH;
   localparam int CNT_W = ssen_pkg::CNT_W;
   localparam int IDX_W = ssen_pkg::IDX_W;
   localparam int POS_W = ssen_pkg::POS_W;
   localparam int DUMP_N = (DEPTH < ssen_pkg::MAX_RESULTS) ? DEPTH : ssen_pkg::MAX_RESULTS;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              busy_ff, busy_in;
   logic [IDX_W-1:0]  dump_idx_ff, dump_idx_in;
   logic [IDX_W-1:0]  dump_end_ff, dump_end_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   ssen_pkg::rsp_type rsp_ff, rsp_in;

   ssen_pkg::cell_ctrl_type            ctrl;
   logic signed [ssen_pkg::DATA_W-1:0] cell_value [DEPTH];
   logic [DEPTH:0]                     hit_chain;
   logic [DEPTH-1:0]                   first_hit;
   logic [POS_W-1:0]                   match_pos;
   logic                               accept, empty, full, found;
   logic [CNT_W-1:0]                   dump_n;

   assign accept = start && !busy_ff;
   assign empty  = (count_ff == '0);
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign found  = hit_chain[DEPTH];
   assign dump_n = (count_ff > CNT_W'(DUMP_N)) ? CNT_W'(DUMP_N) : count_ff;

   // Drive the operation into the cell row
   always_comb begin
      ctrl.key       = req_data.key;
      ctrl.new_value = req_data.new_value;
      ctrl.op        = ssen_pkg::CELL_HOLD;
      if (accept) begin
         case (req_data.mode)
            ssen_pkg::MODE_PUSH:   ctrl.op = full  ? ssen_pkg::CELL_HOLD : ssen_pkg::CELL_PUSH;
            ssen_pkg::MODE_MODIFY: ctrl.op = empty ? ssen_pkg::CELL_HOLD : ssen_pkg::CELL_MODIFY;
            ssen_pkg::MODE_DELETE: ctrl.op = empty ? ssen_pkg::CELL_HOLD : ssen_pkg::CELL_DELETE;
            default:               ctrl.op = ssen_pkg::CELL_HOLD;
         endcase
      end
   end

   // Row of cells, position zero is the top of the stack
   assign hit_chain[0] = 1'b0;
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [ssen_pkg::DATA_W-1:0] above_value;
      logic signed [ssen_pkg::DATA_W-1:0] below_value;
      if (g == 0) begin : g_top
         assign above_value = req_data.new_value;
      end else begin : g_mid
         assign above_value = cell_value[g-1];
      end
      if (g == DEPTH - 1) begin : g_bottom
         assign below_value = cell_value[g];
      end else begin : g_inner
         assign below_value = cell_value[g+1];
      end
      ssen_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .live        (CNT_W'(g) < count_ff),
         .above_value (above_value),
         .below_value (below_value),
         .hit_in      (hit_chain[g]),
         .hit_out     (hit_chain[g+1]),
         .first_hit   (first_hit[g]),
         .value       (cell_value[g])
      );
   end

   // Encode the one-hot first match into a position
   always_comb begin
      match_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (first_hit[i]) begin
            match_pos = match_pos | POS_W'(i);
         end
      end
   end

   // Count, dump sequencing and response beat
   always_comb begin
      count_in        = count_ff;
      busy_in         = busy_ff;
      dump_idx_in     = dump_idx_ff;
      dump_end_in     = dump_end_ff;
      rsp_strobe_in   = 1'b0;
      rsp_in          = rsp_ff;
      rsp_in.position = '0;
      rsp_in.value    = '0;
      rsp_in.last     = 1'b1;
      if (busy_ff) begin
         // emit one dump beat per cycle
         rsp_strobe_in   = 1'b1;
         rsp_in.status   = ssen_pkg::STATUS_DUMP;
         rsp_in.position = POS_W'(dump_idx_ff);
         rsp_in.value    = cell_value[dump_idx_ff];
         rsp_in.last     = (dump_idx_ff == dump_end_ff);
         dump_idx_in     = dump_idx_ff + IDX_W'(1);
         if (dump_idx_ff == dump_end_ff) begin
            busy_in = 1'b0;
         end
      end else if (accept && (req_data.mode <= ssen_pkg::MODE_DUMP)) begin
         rsp_strobe_in = 1'b1;
         if (req_data.mode == ssen_pkg::MODE_PUSH) begin
            if (full) begin
               rsp_in.status = ssen_pkg::STATUS_FULL;
            end else begin
               rsp_in.status = ssen_pkg::STATUS_OK;
               count_in      = count_ff + CNT_W'(1);
            end
         end else if (empty) begin
            rsp_in.status = ssen_pkg::STATUS_EMPTY;
         end else if (req_data.mode == ssen_pkg::MODE_DUMP) begin
            // hold off the beat, sequence entries from the top
            rsp_strobe_in = 1'b0;
            busy_in       = 1'b1;
            dump_idx_in   = '0;
            dump_end_in   = IDX_W'(dump_n - CNT_W'(1));
         end else if (found) begin
            rsp_in.status   = ssen_pkg::STATUS_OK;
            rsp_in.position = match_pos;
            if (req_data.mode == ssen_pkg::MODE_DELETE) begin
               count_in = count_ff - CNT_W'(1);
            end
         end else begin
            rsp_in.status = ssen_pkg::STATUS_NOT_FOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         busy_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         busy_ff       <= busy_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      dump_idx_ff <= dump_idx_in;
      dump_end_ff <= dump_end_in;
      rsp_ff      <= rsp_in;
   end

   assign busy       = busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[rtl/ssen_cell.sv]
// One stack cell: holds a single entry, compares it with the key and shifts
// with its neighbours on push and delete.
// Depends on ssen_pkg.
module ssen_cell (
   input  logic                          clock,
   input  ssen_pkg::cell_ctrl_type       ctrl,
   input  logic                          live,
   input  logic signed [ssen_pkg::DATA_W-1:0] above_value,
   input  logic signed [ssen_pkg::DATA_W-1:0] below_value,
   input  logic                          hit_in,
   output logic                          hit_out,
   output logic                          first_hit,
   output logic signed [ssen_pkg::DATA_W-1:0] value
);

   logic signed [ssen_pkg::DATA_W-1:0] value_ff;
   logic signed [ssen_pkg::DATA_W-1:0] value_in;
   logic                               match;

   // Compare the held entry and pass the hit flag down the row
   assign match     = live && (value_ff == ctrl.key);
   assign first_hit = match && !hit_in;
   assign hit_out   = hit_in || match;
   assign value     = value_ff;

   // Select the next entry
   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         ssen_pkg::CELL_PUSH: begin
            value_in = above_value;
         end
         ssen_pkg::CELL_MODIFY: begin
            if (first_hit) begin
               value_in = ctrl.new_value;
            end
         end
         ssen_pkg::CELL_DELETE: begin
            if (hit_out) begin
               value_in = below_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule
